// ----- src/vrs_pkg.sv -----
// Package for the voxel region statistics unit.
// Holds the datapath command and status types, the widths and the step counts.
// It depends on nothing else.
package vrs_pkg;

    localparam int SumBits  = 48;
    localparam int SqBits   = 62;
    localparam int CntBits  = 31;
    localparam int MagBits  = 47;
    localparam int ProdBits = 93;
    localparam int RadBits  = 108;
    localparam int RootBits = 54;
    localparam int RemBits  = 56;
    localparam int DvdBits  = 56;
    localparam int DrmBits  = 32;
    localparam int StepBits = 6;

    localparam logic [StepBits-1:0] StepsMulA = StepBits'(CntBits - 1);
    localparam logic [StepBits-1:0] StepsMulB = StepBits'(MagBits - 1);
    localparam logic [StepBits-1:0] StepsSqrt = StepBits'(RootBits - 1);
    localparam logic [StepBits-1:0] StepsDiv  = StepBits'(DvdBits - 1);

    localparam logic [2:0] RegRegionEnable = 3'd0;
    localparam logic [2:0] RegXLow  = 3'd1;
    localparam logic [2:0] RegXHigh = 3'd2;
    localparam logic [2:0] RegYLow  = 3'd3;
    localparam logic [2:0] RegYHigh = 3'd4;
    localparam logic [2:0] RegZLow  = 3'd5;
    localparam logic [2:0] RegZHigh = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_LOAD_MULA,
        OP_MULA,
        OP_LOAD_MULB,
        OP_MULB,
        OP_LOAD_SQRT,
        OP_SQRT,
        OP_LOAD_DIVS,
        OP_DIVS,
        OP_LOAD_DIVM,
        OP_DIVM,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

// ----- src/vrs_ctrl.sv -----
// Controller state machine for the voxel region statistics unit.
// Sequences accumulation and the serial multiply, root and divide steps.
// Depends on vrs_pkg.
module vrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_voxel,
    input  vrs_pkg::t_status i_status,
    output logic             o_stall,
    output vrs_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_MULA, S_MULA, S_LD_MULB, S_MULB, S_LD_SQRT, S_SQRT,
        S_LD_DIVS, S_DIVS, S_LD_DIVM, S_DIVM, S_OUT
    } t_state;

    t_state                        r_state;
    logic [vrs_pkg::StepBits-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_last_voxel) r_state <= S_LD_MULA;
                end
                S_LD_MULA: begin
                    r_step  <= '0;
                    r_state <= i_status.cnt_zero ? S_OUT : S_MULA;
                end
                S_MULA: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == vrs_pkg::StepsMulA) r_state <= S_LD_MULB;
                end
                S_LD_MULB: begin
                    r_step  <= '0;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == vrs_pkg::StepsMulB) r_state <= S_LD_SQRT;
                end
                S_LD_SQRT: begin
                    r_step  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == vrs_pkg::StepsSqrt) r_state <= S_LD_DIVS;
                end
                S_LD_DIVS: begin
                    r_step  <= '0;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == vrs_pkg::StepsDiv) r_state <= S_LD_DIVM;
                end
                S_LD_DIVM: begin
                    r_step  <= '0;
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == vrs_pkg::StepsDiv) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_valid ? vrs_pkg::OP_ACC : vrs_pkg::OP_NONE;
            S_LD_MULA: o_cmd.op = vrs_pkg::OP_LOAD_MULA;
            S_MULA:    o_cmd.op = vrs_pkg::OP_MULA;
            S_LD_MULB: o_cmd.op = vrs_pkg::OP_LOAD_MULB;
            S_MULB:    o_cmd.op = vrs_pkg::OP_MULB;
            S_LD_SQRT: o_cmd.op = vrs_pkg::OP_LOAD_SQRT;
            S_SQRT:    o_cmd.op = vrs_pkg::OP_SQRT;
            S_LD_DIVS: o_cmd.op = vrs_pkg::OP_LOAD_DIVS;
            S_DIVS:    o_cmd.op = vrs_pkg::OP_DIVS;
            S_LD_DIVM: o_cmd.op = vrs_pkg::OP_LOAD_DIVM;
            S_DIVM:    o_cmd.op = vrs_pkg::OP_DIVM;
            S_OUT:     o_cmd.op = i_status.out_free ? vrs_pkg::OP_OUT : vrs_pkg::OP_NONE;
            default:   o_cmd.op = vrs_pkg::OP_NONE;
        endcase
    end

    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_last_voxel) |=> o_stall)
        else $error("block not busy after the last word of a volume");
    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= vrs_pkg::StepsDiv + 1'b1)
        else $error("step counter ran past the longest serial operation");
    a_out_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_status.out_free) |=> (r_state == S_IDLE))
        else $error("result written but controller did not return to idle");

endmodule

// ----- src/vrs_dp.sv -----
// Datapath of the voxel region statistics unit: configuration, accumulators,
// serial shift-add multiplier, digit-serial square root, restoring divider.
// Depends on vrs_pkg.
module vrs_dp #(
    parameter int INDEX_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrs_pkg::t_cmd       i_cmd,
    output vrs_pkg::t_status    o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    input  logic signed [15:0]  i_voxel_value,
    input  logic [9:0]          i_x_index,
    input  logic [9:0]          i_y_index,
    input  logic [9:0]          i_z_index,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [30:0]         o_voxel_count,
    output logic signed [15:0]  o_min_value,
    output logic signed [15:0]  o_max_value,
    output logic signed [23:0]  o_mean_fixed,
    output logic [23:0]         o_std_dev_fixed
);

    localparam logic signed [15:0] MinInit = 16'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [15:0] MaxInit = 16'(-(2 ** (SAMPLE_BITS - 1)));
    localparam logic [30:0] CntMax = '1;

    logic r_en;
    logic [9:0] r_xl, r_xh, r_yl, r_yh, r_zl, r_zh;

    logic signed [15:0]                r_min, r_max;
    logic signed [vrs_pkg::SumBits-1:0] r_sum;
    logic [vrs_pkg::SqBits-1:0]         r_sq;
    logic [vrs_pkg::CntBits-1:0]        r_cnt;

    logic [vrs_pkg::ProdBits-1:0] r_prod, r_mcand;
    logic [vrs_pkg::MagBits-1:0]  r_mplier;
    logic [vrs_pkg::RadBits-1:0]  r_rad;
    logic [vrs_pkg::RemBits-1:0]  r_srem;
    logic [vrs_pkg::RootBits-1:0] r_root;
    logic [vrs_pkg::DvdBits-1:0]  r_dvd;
    logic [vrs_pkg::DrmBits-1:0]  r_drem;
    logic [23:0]                  r_std;

    logic signed [SAMPLE_BITS-1:0] s_raw;
    logic signed [15:0]            s_val;
    logic signed [31:0]            s_sqr;
    logic [9:0]                    s_xi, s_yi, s_zi;
    logic                          s_sel;
    logic [vrs_pkg::MagBits-1:0]   s_mag;
    logic [vrs_pkg::RemBits-1:0]   s_srem_t, s_trial;
    logic [vrs_pkg::DrmBits-1:0]   s_drem_t, s_div;
    logic                          s_qbit;
    logic [vrs_pkg::DvdBits-1:0]   s_qa;
    logic [23:0]                   s_mean;

    assign s_raw = i_voxel_value[SAMPLE_BITS-1:0];
    assign s_val = 16'(s_raw);
    assign s_sqr = s_val * s_val;
    assign s_xi  = 10'(i_x_index[INDEX_BITS-1:0]);
    assign s_yi  = 10'(i_y_index[INDEX_BITS-1:0]);
    assign s_zi  = 10'(i_z_index[INDEX_BITS-1:0]);
    assign s_sel = !r_en || (s_xi >= r_xl && s_xi <= r_xh && s_yi >= r_yl && s_yi <= r_yh
                             && s_zi >= r_zl && s_zi <= r_zh);
    assign s_mag = r_sum[vrs_pkg::SumBits-1] ? vrs_pkg::MagBits'(-r_sum)
                                             : vrs_pkg::MagBits'(r_sum);

    // One root digit per step: bring down two radicand bits, try (root << 2) | 1.
    assign s_srem_t = {r_srem[vrs_pkg::RemBits-3:0], r_rad[vrs_pkg::RadBits-1 -: 2]};
    assign s_trial  = {r_root, 2'b01};

    // One quotient bit per step.
    assign s_drem_t = {r_drem[vrs_pkg::DrmBits-2:0], r_dvd[vrs_pkg::DvdBits-1]};
    assign s_div    = vrs_pkg::DrmBits'(r_cnt);
    assign s_qbit   = (s_drem_t >= s_div);

    assign s_qa   = r_dvd + vrs_pkg::DvdBits'(r_drem != '0);
    assign s_mean = r_sum[vrs_pkg::SumBits-1] ? 24'(-s_qa) : r_dvd[23:0];

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_xl <= '0;  r_xh <= '1;
            r_yl <= '0;  r_yh <= '1;
            r_zl <= '0;  r_zh <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vrs_pkg::RegRegionEnable: r_en <= i_cfg_data[0];
                vrs_pkg::RegXLow:  r_xl <= i_cfg_data;
                vrs_pkg::RegXHigh: r_xh <= i_cfg_data;
                vrs_pkg::RegYLow:  r_yl <= i_cfg_data;
                vrs_pkg::RegYHigh: r_yh <= i_cfg_data;
                vrs_pkg::RegZLow:  r_zl <= i_cfg_data;
                vrs_pkg::RegZHigh: r_zh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= MinInit;
            r_max   <= MaxInit;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (i_cmd.op)
                vrs_pkg::OP_ACC: begin
                    if (s_sel && r_cnt != CntMax) begin
                        if (s_val < r_min) r_min <= s_val;
                        if (s_val > r_max) r_max <= s_val;
                        r_sum <= r_sum + vrs_pkg::SumBits'(s_val);
                        r_sq  <= r_sq + vrs_pkg::SqBits'($unsigned(s_sqr));
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                vrs_pkg::OP_OUT: begin
                    o_valid <= 1'b1;
                    r_min   <= MinInit;
                    r_max   <= MaxInit;
                    r_sum   <= '0;
                    r_sq    <= '0;
                    r_cnt   <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            vrs_pkg::OP_LOAD_MULA: begin
                r_prod   <= '0;
                r_mcand  <= vrs_pkg::ProdBits'(r_sq);
                r_mplier <= vrs_pkg::MagBits'(r_cnt);
            end
            vrs_pkg::OP_MULA, vrs_pkg::OP_MULB: begin
                if (r_mplier[0]) begin
                    r_prod <= (i_cmd.op == vrs_pkg::OP_MULA) ? r_prod + r_mcand
                                                             : r_prod - r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
            end
            vrs_pkg::OP_LOAD_MULB: begin
                r_mcand  <= vrs_pkg::ProdBits'(s_mag);
                r_mplier <= s_mag;
            end
            vrs_pkg::OP_LOAD_SQRT: begin
                r_rad  <= {r_prod[vrs_pkg::RadBits-17:0], 16'h0000};
                r_srem <= '0;
                r_root <= '0;
            end
            vrs_pkg::OP_SQRT: begin
                r_rad <= r_rad << 2;
                if (s_srem_t >= s_trial) begin
                    r_srem <= s_srem_t - s_trial;
                    r_root <= {r_root[vrs_pkg::RootBits-2:0], 1'b1};
                end else begin
                    r_srem <= s_srem_t;
                    r_root <= {r_root[vrs_pkg::RootBits-2:0], 1'b0};
                end
            end
            vrs_pkg::OP_LOAD_DIVS: begin
                r_dvd  <= vrs_pkg::DvdBits'(r_root);
                r_drem <= '0;
            end
            vrs_pkg::OP_LOAD_DIVM: begin
                r_std  <= r_dvd[23:0];
                r_dvd  <= {1'b0, s_mag, 8'h00};
                r_drem <= '0;
            end
            vrs_pkg::OP_DIVS, vrs_pkg::OP_DIVM: begin
                r_drem <= s_qbit ? s_drem_t - s_div : s_drem_t;
                r_dvd  <= {r_dvd[vrs_pkg::DvdBits-2:0], s_qbit};
            end
            vrs_pkg::OP_OUT: begin
                if (r_cnt == '0) begin
                    o_voxel_count   <= '0;
                    o_min_value     <= '0;
                    o_max_value     <= '0;
                    o_mean_fixed    <= '0;
                    o_std_dev_fixed <= '0;
                end else begin
                    o_voxel_count   <= r_cnt;
                    o_min_value     <= r_min;
                    o_max_value     <= r_max;
                    o_mean_fixed    <= s_mean;
                    o_std_dev_fixed <= r_std;
                end
            end
            default: ;
        endcase
    end

    a_empty_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_sum == '0 && r_sq == '0))
        else $error("sums nonzero with an empty selection");
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_min <= r_max))
        else $error("running minimum above running maximum");
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vrs_pkg::OP_OUT) |=> (r_cnt == '0 && o_valid))
        else $error("accumulators not cleared after a result");

endmodule

// ----- src/voxel_region_statistics_unit.sv -----
// Voxel region statistics unit: count, min, max, mean and standard deviation.
// Voxel words are taken one per cycle while o_stall is low; a non-last word
// never stalls the input. After the last word the input stalls through load
// steps, 31 + 47 shift-add steps, 54 root digits, 56 + 56 divide steps and an
// output step that makes the result valid; an empty volume skips to that step.
// Reset (synchronous, active low) clears the accumulators and loads the register
// defaults; there is no clearing pass.
module voxel_region_statistics_unit #(
    parameter int INDEX_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_voxel_value,
    input  logic [9:0]         i_x_index,
    input  logic [9:0]         i_y_index,
    input  logic [9:0]         i_z_index,
    input  logic               i_last_voxel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_voxel_count,
    output logic signed [15:0] o_min_value,
    output logic signed [15:0] o_max_value,
    output logic signed [23:0] o_mean_fixed,
    output logic [23:0]        o_std_dev_fixed,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    // The controller only steps the datapath; all arithmetic and the output
    // word register live in the datapath. A finished result waits in that
    // register while the next volume streams in.
    vrs_pkg::t_cmd    s_cmd;
    vrs_pkg::t_status s_status;

    vrs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_voxel (i_last_voxel),
        .i_status     (s_status),
        .o_stall      (o_stall),
        .o_cmd        (s_cmd)
    );

    // The datapath computes the variance as n*S2 - S*S, takes the integer
    // root of that value scaled by 2^16 and divides the root by n, which gives
    // the floored deviation with eight fraction bits.
    vrs_dp #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_status        (s_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_voxel_value   (i_voxel_value),
        .i_x_index       (i_x_index),
        .i_y_index       (i_y_index),
        .i_z_index       (i_z_index),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_voxel_count   (o_voxel_count),
        .o_min_value     (o_min_value),
        .o_max_value     (o_max_value),
        .o_mean_fixed    (o_mean_fixed),
        .o_std_dev_fixed (o_std_dev_fixed)
    );

endmodule
